// ===== rtl/core/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the step sequencer playback block.
// ----------------------------------------------------------------------------
package ssp_pkg;

	localparam int PATTERNS    = 7;
	localparam int MAX_STEPS   = 32;
	localparam int SONG_MAX    = 32;
	localparam int MIN_LEN     = 2;
	localparam int DEFAULT_LEN = 16;

	localparam int PAT_W     = 3;
	localparam int STEP_W    = 5;
	localparam int LEN_W     = 6;
	localparam int DATA_W    = 8;
	localparam int MEM_DEPTH = PATTERNS * MAX_STEPS;
	localparam int MEM_AW    = PAT_W + STEP_W;

	typedef enum logic [3:0] {
		FN_RISE      = 4'd0,
		FN_FALL      = 4'd1,
		FN_RESTART   = 4'd2,
		FN_PLAY_PAT  = 4'd3,
		FN_PLAY_SONG = 4'd4,
		FN_STOP      = 4'd5,
		FN_WR_STEP   = 4'd6,
		FN_WR_SONG   = 4'd7,
		FN_SET_LEN   = 4'd8
	} func_t;

	typedef enum logic [1:0] {
		CFG_GATE_MASK = 2'd0,
		CFG_REVERSE   = 2'd1,
		CFG_SONG_LEN  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_KEEP  = 2'd0,
		OP_LOAD  = 2'd1,
		OP_MASK  = 2'd2,
		OP_CLEAR = 2'd3
	} drv_op_t;

	typedef struct packed {
		logic              playing;
		logic              song;
		logic [PAT_W-1:0]  pat;
		logic [STEP_W-1:0] step;
		logic [STEP_W-1:0] spos;
	} status_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [MEM_AW-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} mem_req_t;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
			input logic [LEN_W-1:0] hi);
		logic [LEN_W-1:0] r;
		r = v;
		if (v < LEN_W'(MIN_LEN)) r = LEN_W'(MIN_LEN);
		else if (v > hi) r = hi;
		return r;
	endfunction

endpackage

// ===== rtl/core/ssp_ifs.sv =====
// ----------------------------------------------------------------------------
// ssp_cmd_if / ssp_rsp_if
// Valid/ready channels carrying command items in and status items out.
// ----------------------------------------------------------------------------
interface ssp_cmd_if;
	logic       valid;
	logic       ready;
	logic [3:0] func;
	logic [2:0] pattern_index;
	logic [4:0] step_index;
	logic [7:0] step_bits;
	logic [5:0] new_length;

	modport source (output valid, func, pattern_index, step_index, step_bits, new_length,
		input ready);
	modport sink (input valid, func, pattern_index, step_index, step_bits, new_length,
		output ready);
endinterface

interface ssp_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] trigger_out;
	logic       is_playing;
	logic       in_song;
	logic [2:0] now_pattern;
	logic [4:0] now_step;
	logic [4:0] now_song_pos;

	modport source (output valid, trigger_out, is_playing, in_song, now_pattern, now_step,
		now_song_pos, input ready);
	modport sink (input valid, trigger_out, is_playing, in_song, now_pattern, now_step,
		now_song_pos, output ready);
endinterface

// ===== rtl/core/ssp_pmem.sv =====
// ----------------------------------------------------------------------------
// ssp_pmem
// Pattern step memory, one write and one registered read per cycle, with
// per-entry valid bits so unwritten steps read as zero after reset.
// ----------------------------------------------------------------------------
module ssp_pmem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ssp_pkg::mem_req_t         req,
	output logic [ssp_pkg::DATA_W-1:0] rdata
);

	logic [ssp_pkg::DATA_W-1:0]    mem [ssp_pkg::MEM_DEPTH];
	logic [ssp_pkg::MEM_DEPTH-1:0] vld_q;
	logic [ssp_pkg::DATA_W-1:0]    rd_q;
	logic                          rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.addr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/core/ssp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssp_ctrl
// Play state, song chain and pattern lengths; works out the next position
// for each item and issues the pattern memory access.
// ----------------------------------------------------------------------------
module ssp_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [3:0]                 func,
	input  logic [ssp_pkg::PAT_W-1:0]  pidx,
	input  logic [ssp_pkg::STEP_W-1:0] sidx,
	input  logic [ssp_pkg::DATA_W-1:0] bits,
	input  logic [ssp_pkg::LEN_W-1:0]  nlen,
	input  logic                       reverse,
	input  logic [ssp_pkg::LEN_W-1:0]  song_len,
	output ssp_pkg::status_t           nxt_stat,
	output ssp_pkg::drv_op_t           op,
	output ssp_pkg::mem_req_t          mreq
);

	logic                       playing_q, song_q, clk_high_q;
	logic [ssp_pkg::PAT_W-1:0]  pat_q;
	logic [ssp_pkg::STEP_W-1:0] step_q, spos_q;
	logic [ssp_pkg::PAT_W-1:0]  song_mem_q [ssp_pkg::SONG_MAX];
	logic [ssp_pkg::LEN_W-1:0]  len_q [ssp_pkg::PATTERNS];

	logic                       playing_n, song_n, clk_high_n;
	logic [ssp_pkg::PAT_W-1:0]  pat_n;
	logic [ssp_pkg::STEP_W-1:0] step_n, spos_n;

	logic                       pid_ok, rev0;
	logic [ssp_pkg::LEN_W-1:0]  spos_inc, step_inc, step_dec, len_rd;
	logic [ssp_pkg::STEP_W-1:0] spos_fwd, spos_back, spos_start, song_addr, len_m1;
	logic [ssp_pkg::PAT_W-1:0]  song_rd, len_addr;

	assign pid_ok     = pidx < ssp_pkg::PAT_W'(ssp_pkg::PATTERNS);
	assign rev0       = reverse && (step_q == '0);
	assign spos_inc   = {1'b0, spos_q} + ssp_pkg::LEN_W'(1);
	assign spos_fwd   = (spos_inc >= song_len) ? '0 : spos_inc[ssp_pkg::STEP_W-1:0];
	assign spos_start = reverse ? ssp_pkg::STEP_W'(song_len - ssp_pkg::LEN_W'(1)) : '0;
	assign spos_back  = (spos_q == '0) ? ssp_pkg::STEP_W'(song_len - ssp_pkg::LEN_W'(1))
		: spos_q - ssp_pkg::STEP_W'(1);
	assign step_inc   = {1'b0, step_q} + ssp_pkg::LEN_W'(1);
	assign step_dec   = {1'b0, step_q} - ssp_pkg::LEN_W'(1);

	always_comb begin
		song_addr = spos_start;
		len_addr  = pat_q;
		case (ssp_pkg::func_t'(func))
			ssp_pkg::FN_RISE: begin
				song_addr = rev0 ? spos_back : spos_fwd;
				len_addr  = (rev0 && song_q) ? song_rd : pat_q;
			end
			ssp_pkg::FN_RESTART: begin
				len_addr = song_q ? song_rd : pat_q;
			end
			ssp_pkg::FN_PLAY_PAT: begin
				len_addr = pidx;
			end
			ssp_pkg::FN_PLAY_SONG: begin
				len_addr = song_rd;
			end
			default: begin
				len_addr = pat_q;
			end
		endcase
	end

	assign song_rd = song_mem_q[song_addr];
	assign len_rd  = (len_addr < ssp_pkg::PAT_W'(ssp_pkg::PATTERNS)) ? len_q[len_addr]
		: ssp_pkg::LEN_W'(ssp_pkg::MIN_LEN);
	assign len_m1  = ssp_pkg::STEP_W'(len_rd - ssp_pkg::LEN_W'(1));

	always_comb begin
		playing_n  = playing_q;
		song_n     = song_q;
		clk_high_n = clk_high_q;
		pat_n      = pat_q;
		step_n     = step_q;
		spos_n     = spos_q;
		op         = ssp_pkg::OP_KEEP;
		mreq       = '0;
		case (ssp_pkg::func_t'(func))
			ssp_pkg::FN_RISE: begin
				if (playing_q) begin
					if (rev0) begin
						if (song_q) begin
							spos_n = spos_back;
							pat_n  = song_rd;
						end
						step_n = len_m1;
					end else if ((reverse ? step_dec : step_inc) >= len_rd) begin
						if (song_q) begin
							spos_n = spos_fwd;
							pat_n  = song_rd;
						end
						step_n = '0;
					end else begin
						step_n = reverse ? step_dec[ssp_pkg::STEP_W-1:0]
							: step_inc[ssp_pkg::STEP_W-1:0];
					end
					clk_high_n = 1'b1;
					op         = ssp_pkg::OP_LOAD;
					mreq.rd_en = 1'b1;
				end
			end
			ssp_pkg::FN_FALL: begin
				clk_high_n = 1'b0;
				op         = ssp_pkg::OP_MASK;
			end
			ssp_pkg::FN_RESTART: begin
				if (playing_q) begin
					if (song_q) begin
						spos_n = spos_start;
						pat_n  = song_rd;
					end
					step_n = reverse ? len_m1 : '0;
					if (clk_high_q) begin
						op         = ssp_pkg::OP_LOAD;
						mreq.rd_en = 1'b1;
					end else begin
						op = ssp_pkg::OP_MASK;
					end
				end
			end
			ssp_pkg::FN_PLAY_PAT: begin
				if (pid_ok) begin
					playing_n = 1'b1;
					song_n    = 1'b0;
					pat_n     = pidx;
					step_n    = reverse ? len_m1 : '0;
				end
			end
			ssp_pkg::FN_PLAY_SONG: begin
				playing_n = 1'b1;
				song_n    = 1'b1;
				spos_n    = spos_start;
				pat_n     = song_rd;
				step_n    = reverse ? len_m1 : '0;
			end
			ssp_pkg::FN_STOP: begin
				playing_n = 1'b0;
				song_n    = 1'b0;
				op        = ssp_pkg::OP_CLEAR;
			end
			ssp_pkg::FN_WR_STEP: begin
				mreq.wr_en = pid_ok;
			end
			default: begin
				op = ssp_pkg::OP_KEEP;
			end
		endcase
		if (mreq.wr_en) begin
			mreq.addr  = {pidx, sidx};
			mreq.wdata = bits;
		end else begin
			mreq.addr = {pat_n, step_n};
		end
	end

	assign nxt_stat.playing = playing_n;
	assign nxt_stat.song    = song_n;
	assign nxt_stat.pat     = pat_n;
	assign nxt_stat.step    = step_n;
	assign nxt_stat.spos    = song_n ? spos_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q  <= 1'b0;
			song_q     <= 1'b0;
			clk_high_q <= 1'b0;
			pat_q      <= '0;
			step_q     <= '0;
			spos_q     <= '0;
			for (int i = 0; i < ssp_pkg::SONG_MAX; i++) begin
				song_mem_q[i] <= '0;
			end
			for (int i = 0; i < ssp_pkg::PATTERNS; i++) begin
				len_q[i] <= ssp_pkg::LEN_W'(ssp_pkg::DEFAULT_LEN);
			end
		end else if (accept) begin
			playing_q  <= playing_n;
			song_q     <= song_n;
			clk_high_q <= clk_high_n;
			pat_q      <= pat_n;
			step_q     <= step_n;
			spos_q     <= spos_n;
			if (pid_ok && (ssp_pkg::func_t'(func) == ssp_pkg::FN_WR_SONG)) begin
				song_mem_q[sidx] <= pidx;
			end
			if (pid_ok && (ssp_pkg::func_t'(func) == ssp_pkg::FN_SET_LEN)) begin
				len_q[pidx] <= ssp_pkg::clamp_len(nlen, ssp_pkg::LEN_W'(ssp_pkg::MAX_STEPS));
			end
		end
	end

endmodule

// ===== rtl/core/ssp_out.sv =====
// ----------------------------------------------------------------------------
// ssp_out
// Output stage: latches the step read from memory, forms the driven levels
// and holds the status item until it is taken.
// ----------------------------------------------------------------------------
module ssp_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  ssp_pkg::drv_op_t           op,
	input  ssp_pkg::status_t           stat_in,
	input  logic [ssp_pkg::DATA_W-1:0] rdata,
	input  logic [ssp_pkg::DATA_W-1:0] gate_mask,
	input  logic                       out_ready,
	output logic                       free,
	output logic                       out_valid,
	output logic [ssp_pkg::DATA_W-1:0] drv,
	output ssp_pkg::status_t           stat_out
);

	logic                       v_s2;
	logic [ssp_pkg::DATA_W-1:0] lat_q, drv_q;
	ssp_pkg::status_t           stat_s2;
	logic                       load;

	assign free = !v_s2 || out_ready;
	assign load = in_valid && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			lat_q <= '0;
			drv_q <= '0;
		end else begin
			if (load) begin
				v_s2 <= 1'b1;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
			if (load) begin
				case (op)
					ssp_pkg::OP_LOAD: begin
						lat_q <= rdata;
						drv_q <= rdata | ssp_pkg::DATA_W'(1);
					end
					ssp_pkg::OP_MASK: begin
						drv_q <= lat_q & gate_mask;
					end
					ssp_pkg::OP_CLEAR: begin
						lat_q <= '0;
						drv_q <= '0;
					end
					default: begin
						drv_q <= drv_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			stat_s2 <= stat_in;
		end
	end

	assign out_valid = v_s2;
	assign drv       = drv_q;
	assign stat_out  = stat_s2;

endmodule

// ===== rtl/core/step_sequencer_playback.sv =====
// ----------------------------------------------------------------------------
// step_sequencer_playback
// Gate and trigger step sequencer with a song chain, driven by command items.
// ----------------------------------------------------------------------------
// Each command item returns one status item. The block takes one item per
// clock when the status side keeps up: the play state updates in the accept
// cycle, the pattern step memory is read once at that edge, and the status
// item passes the read stage and the output register. A full output register
// plus the memory read stage let two items be in flight, so input stays ready
// while a finished status item waits. The step store needs no clearing pass.
module step_sequencer_playback (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data,
	ssp_cmd_if.sink          cmd,
	ssp_rsp_if.source        rsp
);

	logic [ssp_pkg::DATA_W-1:0] gate_mask_q;
	logic                       reverse_q;
	logic [ssp_pkg::LEN_W-1:0]  song_len_q;

	logic                       accept, s2_free, v_s1_q;
	ssp_pkg::status_t           nxt_stat, stat_s1, stat_out;
	ssp_pkg::drv_op_t           op, op_s1;
	ssp_pkg::mem_req_t          mreq, pmem_req;
	logic [ssp_pkg::DATA_W-1:0] rdata, drv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_mask_q <= '0;
			reverse_q   <= 1'b0;
			song_len_q  <= ssp_pkg::LEN_W'(16);
		end else if (cfg_we) begin
			case (ssp_pkg::cfg_idx_t'(cfg_index))
				ssp_pkg::CFG_GATE_MASK: gate_mask_q <= cfg_data;
				ssp_pkg::CFG_REVERSE:   reverse_q   <= cfg_data[0];
				ssp_pkg::CFG_SONG_LEN: begin
					song_len_q <= ssp_pkg::clamp_len(cfg_data[ssp_pkg::LEN_W-1:0],
						ssp_pkg::LEN_W'(ssp_pkg::SONG_MAX));
				end
				default: begin
					song_len_q <= song_len_q;
				end
			endcase
		end
	end

	assign cmd.ready = !v_s1_q || s2_free;
	assign accept    = cmd.valid && cmd.ready;

	ssp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.func     (cmd.func),
		.pidx     (cmd.pattern_index),
		.sidx     (cmd.step_index),
		.bits     (cmd.step_bits),
		.nlen     (cmd.new_length),
		.reverse  (reverse_q),
		.song_len (song_len_q),
		.nxt_stat (nxt_stat),
		.op       (op),
		.mreq     (mreq)
	);

	assign pmem_req.rd_en = mreq.rd_en && accept;
	assign pmem_req.wr_en = mreq.wr_en && accept;
	assign pmem_req.addr  = mreq.addr;
	assign pmem_req.wdata = mreq.wdata;

	ssp_pmem u_pmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pmem_req),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (accept) begin
			v_s1_q <= 1'b1;
		end else if (s2_free) begin
			v_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			stat_s1 <= nxt_stat;
		end
	end

	ssp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1_q),
		.op        (op_s1),
		.stat_in   (stat_s1),
		.rdata     (rdata),
		.gate_mask (gate_mask_q),
		.out_ready (rsp.ready),
		.free      (s2_free),
		.out_valid (rsp.valid),
		.drv       (drv),
		.stat_out  (stat_out)
	);

	assign rsp.trigger_out  = drv;
	assign rsp.is_playing   = stat_out.playing;
	assign rsp.in_song      = stat_out.song;
	assign rsp.now_pattern  = stat_out.pat;
	assign rsp.now_step     = stat_out.step;
	assign rsp.now_song_pos = stat_out.spos;

`ifndef ASSERT_OFF
	a_song_needs_play: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.in_song |-> rsp.is_playing)
		else $error("song mode reported while stopped");

	a_song_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.in_song |-> rsp.now_song_pos == '0)
		else $error("song position nonzero outside song mode");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1_q && !s2_free |=> v_s1_q && $stable(op_s1))
		else $error("stalled item lost from read stage");

	a_pattern_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.now_pattern < ssp_pkg::PAT_W'(ssp_pkg::PATTERNS))
		else $error("pattern number out of range");
`endif

endmodule
